[src/assert_macros.svh]
// assertion macros used by flow_table_packet_counter
// depends on nothing; users provide clk_i and rst_ni in scope
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked property check, disabled while in reset
`define FTPC_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// implication check, disabled while in reset
`define FTPC_ASSERT_IMPL(name, pre, post, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |-> (post)) \
    else $error(msg);

`endif

[src/ftpc_pkg.sv]
// package for the flow table packet counter: widths, reset values, fsm codes
// no dependencies
package ftpc_pkg;

  localparam int unsigned KEY_W    = 104;
  localparam int unsigned PKT_W    = 40;
  localparam int unsigned BYTE_W   = 48;
  localparam int unsigned TIME_W   = 32;
  localparam int unsigned LEN_W    = 16;
  localparam int unsigned EXP_W    = 16;
  localparam int unsigned ENTRY_W  = PKT_W + BYTE_W + TIME_W;

  localparam logic [EXP_W-1:0]  EXPIRY_RESET = 16'd100;
  localparam logic [PKT_W-1:0]  PKT_MAX      = {PKT_W{1'b1}};
  localparam logic [BYTE_W-1:0] BYTE_MAX     = {BYTE_W{1'b1}};

  localparam logic REG_EXPIRY = 1'b0;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_READ,
    ST_MOD,
    ST_LINK,
    ST_HEAD,
    ST_EXP
  } state_e;

  typedef struct packed {
    logic done;
    logic hit;
  } srch_res_t;

endpackage

[src/ftpc_key_search.sv]
// key memory with a sequential search over the filled entries
// depends on ftpc_pkg
module ftpc_key_search #(
  parameter int unsigned FLOW_ENTRIES = 1024
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               start_i,
  input  logic [ftpc_pkg::KEY_W-1:0]         key_i,
  input  logic [$clog2(FLOW_ENTRIES+1)-1:0]  in_use_i,
  input  logic                               wr_en_i,
  input  logic [$clog2(FLOW_ENTRIES)-1:0]    wr_addr_i,
  output ftpc_pkg::srch_res_t                res_o,
  output logic [$clog2(FLOW_ENTRIES)-1:0]    slot_o
);

  localparam int unsigned SLOT_W = $clog2(FLOW_ENTRIES);
  localparam int unsigned CNT_W  = $clog2(FLOW_ENTRIES + 1);

  logic [ftpc_pkg::KEY_W-1:0] key_mem [FLOW_ENTRIES];
  logic [ftpc_pkg::KEY_W-1:0] rd_key_q;

  logic              act_q, act_d;
  logic [CNT_W-1:0]  idx_q, idx_d;
  logic              cmp_vld_q, cmp_vld_d;
  logic [SLOT_W-1:0] cmp_idx_q, cmp_idx_d;
  logic              rd_en;
  logic              match;

  assign match = act_q && cmp_vld_q && (rd_key_q == key_i);

  always_comb begin
    act_d     = act_q;
    idx_d     = idx_q;
    cmp_vld_d = 1'b0;
    cmp_idx_d = cmp_idx_q;
    rd_en     = 1'b0;
    res_o     = '0;
    if (start_i) begin
      act_d = 1'b1;
      idx_d = '0;
    end else if (act_q) begin
      if (match) begin
        res_o.done = 1'b1;
        res_o.hit  = 1'b1;
        act_d      = 1'b0;
      end else if (idx_q < in_use_i) begin
        // pipelined: issue next address while comparing the previous one
        rd_en     = 1'b1;
        cmp_vld_d = 1'b1;
        cmp_idx_d = idx_q[SLOT_W-1:0];
        idx_d     = idx_q + CNT_W'(1);
      end else if (!cmp_vld_q) begin
        res_o.done = 1'b1;
        act_d      = 1'b0;
      end
    end
  end

  assign slot_o = cmp_idx_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      act_q     <= 1'b0;
      idx_q     <= '0;
      cmp_vld_q <= 1'b0;
      cmp_idx_q <= '0;
    end else begin
      act_q     <= act_d;
      idx_q     <= idx_d;
      cmp_vld_q <= cmp_vld_d;
      cmp_idx_q <= cmp_idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      key_mem[wr_addr_i] <= key_i;
    end
    if (rd_en) begin
      rd_key_q <= key_mem[idx_q[SLOT_W-1:0]];
    end
  end

endmodule

[src/flow_table_packet_counter.sv]
// Per-flow packet and byte counter keyed by the IPv4 5-tuple, with an expiry check on the
// least recently updated flow. A request is accepted only in the idle state, once the
// result of the previous one is in the output register. For each request the key memory
// is searched one entry per cycle over the in_use filled entries through its single read
// port; then the counter and link memories are read (for a known flow only), updated and
// written back, and the new oldest entry is read for the expiry compare. Entries fill in
// order 0, 1, 2 and so on, never evicted; a new flow on a full table gets table_full_o and
// is not counted. Depends on ftpc_pkg, ftpc_key_search and assert_macros.svh.
`include "assert_macros.svh"

module flow_table_packet_counter #(
  parameter int unsigned FLOW_ENTRIES = 1024
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [2:0]                          paddr,
  input  logic [31:0]                         pwdata,
  output logic [31:0]                         prdata,
  output logic                                pready,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic [31:0]                         source_ip_i,
  input  logic [31:0]                         dest_ip_i,
  input  logic [15:0]                         source_port_i,
  input  logic [15:0]                         dest_port_i,
  input  logic [7:0]                          protocol_i,
  input  logic [15:0]                         packet_length_i,
  input  logic [31:0]                         now_seconds_i,
  input  logic                                end_of_burst_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic [$clog2(FLOW_ENTRIES)-1:0]     flow_slot_o,
  output logic                                new_flow_o,
  output logic                                table_full_o,
  output logic [39:0]                         flow_packets_o,
  output logic [47:0]                         flow_bytes_o,
  output logic                                oldest_expired_o
);

  localparam int unsigned SLOT_W = $clog2(FLOW_ENTRIES);
  localparam int unsigned CNT_W  = $clog2(FLOW_ENTRIES + 1);
  localparam int unsigned PKT_W  = ftpc_pkg::PKT_W;
  localparam int unsigned BYTE_W = ftpc_pkg::BYTE_W;
  localparam int unsigned TIME_W = ftpc_pkg::TIME_W;

  ftpc_pkg::state_e state_q, state_d;

  logic [ftpc_pkg::EXP_W-1:0]   expiry_q;
  logic [ftpc_pkg::KEY_W-1:0]   key_q;
  logic [ftpc_pkg::LEN_W-1:0]   len_q;
  logic [TIME_W-1:0]            now_q;
  logic [SLOT_W-1:0]            slot_q, slot_d;
  logic                         hit_q, hit_d, new_q, new_d, full_q, full_d;
  logic [SLOT_W-1:0]            head_q, head_d, tail_q, tail_d;
  logic [CNT_W-1:0]             in_use_q, in_use_d;
  logic [PKT_W-1:0]             pk_q, pk_d;
  logic [BYTE_W-1:0]            by_q, by_d;

  logic                         out_vld_q, out_vld_d;
  logic [SLOT_W-1:0]            o_slot_q;
  logic                         o_new_q, o_full_q, o_exp_q;
  logic [PKT_W-1:0]             o_pk_q;
  logic [BYTE_W-1:0]            o_by_q;
  logic                         out_load;

  // counter memory entry: packets, bytes, last seen
  logic [ftpc_pkg::ENTRY_W-1:0] cnt_mem [FLOW_ENTRIES];
  logic [SLOT_W-1:0]            nxt_mem [FLOW_ENTRIES];
  logic [SLOT_W-1:0]            prv_mem [FLOW_ENTRIES];
  logic [ftpc_pkg::ENTRY_W-1:0] cnt_rd_q;
  logic [SLOT_W-1:0]            nxt_rd_q, prv_rd_q;

  logic                         cnt_re, lnk_re, cnt_we, key_we;
  logic [SLOT_W-1:0]            cnt_raddr;
  logic                         nxt_we, prv_we;
  logic [SLOT_W-1:0]            nxt_waddr, nxt_wdata, prv_waddr, prv_wdata;

  logic                         start;
  logic                         in_acc;
  logic                         cfg_we;
  logic                         moving;
  ftpc_pkg::srch_res_t          srch;
  logic [SLOT_W-1:0]            srch_slot;

  logic [PKT_W-1:0]             old_pk;
  logic [BYTE_W-1:0]            old_by;
  logic [BYTE_W:0]              by_sum;
  logic [TIME_W:0]              lim;
  logic                         expired;

  // apb register
  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && (paddr[2] == ftpc_pkg::REG_EXPIRY);
  assign prdata = (paddr[2] == ftpc_pkg::REG_EXPIRY) ? {16'd0, expiry_q} : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      expiry_q <= ftpc_pkg::EXPIRY_RESET;
    end else if (cfg_we) begin
      expiry_q <= pwdata[ftpc_pkg::EXP_W-1:0];
    end
  end

  assign in_ready_o = (state_q == ftpc_pkg::ST_IDLE);
  assign in_acc     = in_valid_i && in_ready_o;
  assign start      = in_acc;
  assign moving     = hit_q && (slot_q != tail_q);

  ftpc_key_search #(
    .FLOW_ENTRIES(FLOW_ENTRIES)
  ) u_search (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (start),
    .key_i     (key_q),
    .in_use_i  (in_use_q),
    .wr_en_i   (key_we),
    .wr_addr_i (slot_q),
    .res_o     (srch),
    .slot_o    (srch_slot)
  );

  assign old_pk  = new_q ? '0 : cnt_rd_q[ftpc_pkg::ENTRY_W-1 -: PKT_W];
  assign old_by  = new_q ? '0 : cnt_rd_q[TIME_W +: BYTE_W];
  assign by_sum  = {1'b0, old_by} + (BYTE_W+1)'(len_q);
  assign lim     = {1'b0, cnt_rd_q[TIME_W-1:0]} + (TIME_W+1)'(expiry_q);
  assign expired = (in_use_q != '0) && (lim < {1'b0, now_q});

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ftpc_pkg::ST_IDLE: if (in_acc) state_d = ftpc_pkg::ST_SCAN;
      ftpc_pkg::ST_SCAN: begin
        if (srch.done) begin
          if (srch.hit) begin
            state_d = ftpc_pkg::ST_READ;
          end else if (in_use_q == CNT_W'(FLOW_ENTRIES)) begin
            state_d = ftpc_pkg::ST_HEAD;
          end else begin
            state_d = ftpc_pkg::ST_MOD;
          end
        end
      end
      ftpc_pkg::ST_READ: state_d = ftpc_pkg::ST_MOD;
      ftpc_pkg::ST_MOD:  state_d = ftpc_pkg::ST_LINK;
      ftpc_pkg::ST_LINK: state_d = ftpc_pkg::ST_HEAD;
      ftpc_pkg::ST_HEAD: state_d = ftpc_pkg::ST_EXP;
      ftpc_pkg::ST_EXP:  if (out_load) state_d = ftpc_pkg::ST_IDLE;
      default:           state_d = ftpc_pkg::ST_IDLE;
    endcase
  end

  // datapath and memory controls
  always_comb begin
    slot_d    = slot_q;
    hit_d     = hit_q;
    new_d     = new_q;
    full_d    = full_q;
    head_d    = head_q;
    tail_d    = tail_q;
    in_use_d  = in_use_q;
    pk_d      = pk_q;
    by_d      = by_q;
    cnt_re    = 1'b0;
    cnt_raddr = slot_q;
    lnk_re    = 1'b0;
    cnt_we    = 1'b0;
    key_we    = 1'b0;
    nxt_we    = 1'b0;
    nxt_waddr = tail_q;
    nxt_wdata = slot_q;
    prv_we    = 1'b0;
    prv_waddr = slot_q;
    prv_wdata = tail_q;
    out_load  = 1'b0;
    case (state_q)
      ftpc_pkg::ST_IDLE: begin
        if (in_acc) begin
          hit_d  = 1'b0;
          new_d  = 1'b0;
          full_d = 1'b0;
        end
      end
      ftpc_pkg::ST_SCAN: begin
        if (srch.done) begin
          if (srch.hit) begin
            slot_d = srch_slot;
            hit_d  = 1'b1;
          end else if (in_use_q == CNT_W'(FLOW_ENTRIES)) begin
            full_d = 1'b1;
          end else begin
            slot_d = in_use_q[SLOT_W-1:0];
            new_d  = 1'b1;
          end
        end
      end
      ftpc_pkg::ST_READ: begin
        cnt_re = 1'b1;
        lnk_re = 1'b1;
      end
      ftpc_pkg::ST_MOD: begin
        pk_d   = (old_pk == ftpc_pkg::PKT_MAX) ? old_pk : old_pk + PKT_W'(1);
        by_d   = by_sum[BYTE_W] ? ftpc_pkg::BYTE_MAX : by_sum[BYTE_W-1:0];
        cnt_we = 1'b1;
        key_we = new_q;
        // unlink from the current place in the order
        if (moving) begin
          prv_we    = 1'b1;
          prv_waddr = nxt_rd_q;
          prv_wdata = prv_rd_q;
          if (slot_q == head_q) begin
            head_d = nxt_rd_q;
          end else begin
            nxt_we    = 1'b1;
            nxt_waddr = prv_rd_q;
            nxt_wdata = nxt_rd_q;
          end
        end
      end
      ftpc_pkg::ST_LINK: begin
        // append at the tail
        if (moving || (new_q && (in_use_q != '0))) begin
          nxt_we = 1'b1;
          prv_we = 1'b1;
        end
        if (moving || new_q) begin
          tail_d = slot_q;
        end
        if (new_q) begin
          if (in_use_q == '0) head_d = slot_q;
          in_use_d = in_use_q + CNT_W'(1);
        end
      end
      ftpc_pkg::ST_HEAD: begin
        cnt_re    = 1'b1;
        cnt_raddr = head_q;
      end
      ftpc_pkg::ST_EXP: begin
        out_load = !out_vld_q || out_ready_i;
      end
      default: ;
    endcase
  end

  assign out_vld_d = out_load ? 1'b1 : (out_vld_q && !out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ftpc_pkg::ST_IDLE;
      hit_q     <= 1'b0;
      new_q     <= 1'b0;
      full_q    <= 1'b0;
      head_q    <= '0;
      tail_q    <= '0;
      in_use_q  <= '0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      hit_q     <= hit_d;
      new_q     <= new_d;
      full_q    <= full_d;
      head_q    <= head_d;
      tail_q    <= tail_d;
      in_use_q  <= in_use_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      key_q <= {source_ip_i, dest_ip_i, source_port_i, dest_port_i, protocol_i};
      len_q <= packet_length_i;
      now_q <= now_seconds_i;
    end
    slot_q <= slot_d;
    pk_q   <= pk_d;
    by_q   <= by_d;
    if (out_load) begin
      o_slot_q <= full_q ? '0 : slot_q;
      o_new_q  <= new_q;
      o_full_q <= full_q;
      o_pk_q   <= full_q ? '0 : pk_q;
      o_by_q   <= full_q ? '0 : by_q;
      o_exp_q  <= expired;
    end
  end

  // memories
  always_ff @(posedge clk_i) begin
    if (cnt_we) begin
      cnt_mem[slot_q] <= {pk_d, by_d, now_q};
    end
    if (cnt_re) begin
      cnt_rd_q <= cnt_mem[cnt_raddr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (nxt_we) begin
      nxt_mem[nxt_waddr] <= nxt_wdata;
    end
    if (prv_we) begin
      prv_mem[prv_waddr] <= prv_wdata;
    end
    if (lnk_re) begin
      nxt_rd_q <= nxt_mem[slot_q];
      prv_rd_q <= prv_mem[slot_q];
    end
  end

  assign out_valid_o      = out_vld_q;
  assign flow_slot_o      = o_slot_q;
  assign new_flow_o       = o_new_q;
  assign table_full_o     = o_full_q;
  assign flow_packets_o   = o_pk_q;
  assign flow_bytes_o     = o_by_q;
  assign oldest_expired_o = o_exp_q;

  `FTPC_ASSERT(a_in_use_bound, in_use_q <= CNT_W'(FLOW_ENTRIES), "flow count past table size")
  `FTPC_ASSERT_IMPL(a_in_use_step, in_use_q != $past(in_use_q),
    in_use_q == $past(in_use_q) + CNT_W'(1), "flow count moved by more than one")
  `FTPC_ASSERT_IMPL(a_new_not_full, out_vld_q, !(o_new_q && o_full_q),
    "new flow reported with full table")
  `FTPC_ASSERT_IMPL(a_full_no_grow, state_q == ftpc_pkg::ST_EXP && full_q,
    in_use_q == CNT_W'(FLOW_ENTRIES), "full flag with free entries")

endmodule

[tb/sv/tb_flow_table_packet_counter.sv]
`timescale 1ns / 1ps
// self-checking testbench for flow_table_packet_counter: directed, random, backpressure and
// table-fill tests against an in-bench flow table predictor; depends on ftpc_pkg and the rtl
module tb_flow_table_packet_counter;

  localparam int unsigned ENTRIES = 1024;
  localparam int unsigned SLOT_W = $clog2(ENTRIES);
  localparam int unsigned PKT_W = ftpc_pkg::PKT_W;
  localparam int unsigned BYTE_W = ftpc_pkg::BYTE_W;
  localparam int unsigned EXP_W = ftpc_pkg::EXP_W;
  localparam longint unsigned CYCLE_LIMIT = 20_000_000;
  localparam logic [2:0] ADDR_EXPIRY = 3'd0;

  typedef struct packed {
    logic [31:0] sip;
    logic [31:0] dip;
    logic [15:0] sport;
    logic [15:0] dport;
    logic [7:0]  proto;
  } flow_key_t;

  typedef struct packed {
    flow_key_t   key;
    logic [15:0] len;
    logic [31:0] now;
    logic        eob;
  } packet_t;

  typedef struct packed {
    logic [SLOT_W-1:0] slot;
    logic              made;
    logic              full;
    logic [PKT_W-1:0]  pkts;
    logic [BYTE_W-1:0] bytes;
    logic              expired;
  } count_result_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [2:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  packet_t pkt_q = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  count_result_t res_o;

  flow_table_packet_counter #(.FLOW_ENTRIES(ENTRIES)) u_dut (
    .clk_i, .rst_ni, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .in_valid_i, .in_ready_o,
    .source_ip_i(pkt_q.key.sip), .dest_ip_i(pkt_q.key.dip),
    .source_port_i(pkt_q.key.sport), .dest_port_i(pkt_q.key.dport),
    .protocol_i(pkt_q.key.proto), .packet_length_i(pkt_q.len),
    .now_seconds_i(pkt_q.now), .end_of_burst_i(pkt_q.eob),
    .out_valid_o, .out_ready_i,
    .flow_slot_o(res_o.slot), .new_flow_o(res_o.made), .table_full_o(res_o.full),
    .flow_packets_o(res_o.pkts), .flow_bytes_o(res_o.bytes),
    .oldest_expired_o(res_o.expired)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // flow table predictor state
  flow_key_t         tbl_key [ENTRIES];
  logic              tbl_valid [ENTRIES];
  logic [PKT_W-1:0]  tbl_pkts [ENTRIES];
  logic [BYTE_W-1:0] tbl_bytes [ENTRIES];
  logic [31:0]       tbl_seen [ENTRIES];
  int unsigned       lru_next [ENTRIES];
  int unsigned       lru_prev [ENTRIES];
  int unsigned       lru_head, lru_tail, flows_used;
  logic [EXP_W-1:0]  expiry_cfg;

  count_result_t expected_counts[$];
  int unsigned   mismatches = 0;
  longint unsigned cycles = 0;
  bit            no_idle = 1'b0;
  int unsigned   hold_off = 0;
  logic [31:0]   clock_now = 0;
  flow_key_t     key_pool [48];

  function automatic count_result_t count_packet(packet_t p);
    count_result_t r;
    int found;
    int unsigned s, nx, pv;
    logic [BYTE_W:0] sum;
    r = '0;
    found = -1;
    for (int i = 0; i < ENTRIES; i++)
      if (found < 0 && tbl_valid[i] && tbl_key[i] == p.key) found = i;
    if (found < 0) begin
      if (flows_used >= ENTRIES) begin
        r.full = 1'b1;
      end else begin
        s = flows_used;
        tbl_key[s] = p.key;
        tbl_valid[s] = 1'b1;
        tbl_pkts[s] = '0;
        tbl_bytes[s] = '0;
        if (flows_used == 0) begin
          lru_head = s;
        end else begin
          lru_next[lru_tail] = s;
          lru_prev[s] = lru_tail;
        end
        lru_tail = s;
        flows_used++;
        r.made = 1'b1;
      end
    end else begin
      s = found;
      if (s != lru_tail) begin
        nx = lru_next[s];
        pv = lru_prev[s];
        if (s == lru_head) lru_head = nx;
        else lru_next[pv] = nx;
        lru_prev[nx] = pv;
        lru_prev[s] = lru_tail;
        lru_next[lru_tail] = s;
        lru_tail = s;
      end
    end
    if (!r.full) begin
      if (tbl_pkts[s] != ftpc_pkg::PKT_MAX) tbl_pkts[s]++;
      sum = {1'b0, tbl_bytes[s]} + (BYTE_W+1)'(p.len);
      tbl_bytes[s] = sum[BYTE_W] ? ftpc_pkg::BYTE_MAX : sum[BYTE_W-1:0];
      tbl_seen[s] = p.now;
      r.slot = SLOT_W'(s);
      r.pkts = tbl_pkts[s];
      r.bytes = tbl_bytes[s];
    end
    if (flows_used > 0)
      r.expired = ({1'b0, tbl_seen[lru_head]} + 33'(expiry_cfg)) < {1'b0, p.now};
    return r;
  endfunction

  task automatic apb_write(input logic [2:0] addr, input logic [31:0] data);
    @(negedge clk_i);
    psel <= 1'b1; pwrite <= 1'b1; paddr <= addr; pwdata <= data; penable <= 1'b0;
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    if (addr == ADDR_EXPIRY) expiry_cfg = data[EXP_W-1:0];
    @(negedge clk_i);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
  endtask

  task automatic send_packet(input packet_t p);
    @(negedge clk_i);
    while (!no_idle && $urandom_range(99) < 31) @(negedge clk_i);
    in_valid_i <= 1'b1;
    pkt_q <= p;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    expected_counts.push_back(count_packet(p));
    @(negedge clk_i);
    in_valid_i <= 1'b0;
  endtask

  task automatic wait_drained();
    while (expected_counts.size() != 0) @(posedge clk_i);
    repeat (flows_used + 16) @(posedge clk_i);
  endtask

  function automatic flow_key_t random_key();
    flow_key_t k;
    k.sip = $urandom; k.dip = $urandom;
    k.sport = 16'($urandom); k.dport = 16'($urandom); k.proto = 8'($urandom);
    return k;
  endfunction

  function automatic packet_t make_packet(flow_key_t k);
    packet_t p;
    p.key = k;
    p.len = 16'($urandom);
    if ($urandom_range(99) < 5) begin
      clock_now = $urandom;  // includes time going backwards
    end else begin
      clock_now = clock_now + $urandom_range(120);
    end
    p.now = clock_now;
    p.eob = 1'($urandom);
    return p;
  endfunction

  task automatic test_directed();
    packet_t p;
    flow_key_t kmax, kmin;
    kmax = '1;
    kmin = '0;
    // empty table, first flow, hit, extremes of every field
    p = '{key: kmin, len: 16'd0, now: 32'd0, eob: 1'b0};
    send_packet(p);
    p = '{key: kmin, len: 16'hFFFF, now: 32'd50, eob: 1'b1};
    send_packet(p);
    p = '{key: kmax, len: 16'hFFFF, now: 32'd100, eob: 1'b0};
    send_packet(p);
    // oldest flow on the edge of expiry and just past it
    p = '{key: kmax, len: 16'd1, now: 32'd150, eob: 1'b1};
    send_packet(p);
    p = '{key: kmax, len: 16'd1, now: 32'd151, eob: 1'b0};
    send_packet(p);
    // time going backwards, then time at its top
    p = '{key: kmin, len: 16'd7, now: 32'd3, eob: 1'b0};
    send_packet(p);
    p = '{key: kmax, len: 16'd9, now: 32'hFFFF_FFFF, eob: 1'b1};
    send_packet(p);
    for (int i = 0; i < 8; i++) begin
      p = '{key: random_key(), len: 16'($urandom), now: 32'h8000_0000 + i, eob: i[0]};
      send_packet(p);
    end
    clock_now = 32'd1000;
  endtask

  task automatic test_expiry_settings();
    logic [15:0] settings [4];
    packet_t p;
    settings = '{16'd0, 16'hFFFF, 16'd1, 16'd100};
    foreach (settings[i]) begin
      wait_drained();
      apb_write(ADDR_EXPIRY, {16'd0, settings[i]});
      for (int j = 0; j < 10; j++) begin
        p = make_packet(key_pool[$urandom_range(7)]);
        send_packet(p);
      end
    end
  endtask

  task automatic test_random_traffic(input int unsigned n_items);
    packet_t p;
    for (int unsigned i = 0; i < n_items; i++) begin
      no_idle = (i % 300) >= 220;
      if (i % 200 == 199) begin
        wait_drained();
        apb_write(ADDR_EXPIRY, $urandom);
      end
      if ($urandom_range(99) < 85) p = make_packet(key_pool[$urandom_range(47)]);
      else p = make_packet(random_key());
      send_packet(p);
    end
    no_idle = 1'b0;
  endtask

  task automatic test_backpressure();
    packet_t p;
    hold_off = 400;
    for (int i = 0; i < 12; i++) begin
      p = make_packet(key_pool[$urandom_range(47)]);
      send_packet(p);
    end
  endtask

  task automatic test_table_fill();
    packet_t p;
    wait_drained();
    apb_write(ADDR_EXPIRY, 32'd1000);
    while (flows_used < ENTRIES) begin
      p = make_packet(random_key());
      send_packet(p);
    end
    // misses on a full table mixed with hits
    for (int i = 0; i < 30; i++) begin
      if (i[0]) p = make_packet(random_key());
      else p = make_packet(key_pool[$urandom_range(47)]);
      send_packet(p);
    end
  endtask

  // result receiver with random and long stalls
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else if (hold_off > 0) begin
      hold_off <= hold_off - 1;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= no_idle || ($urandom_range(99) >= 31);
    end
  end

  always @(posedge clk_i) begin
    count_result_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_counts.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %p", res_o);
      end else begin
        want = expected_counts.pop_front();
        if (want.slot !== res_o.slot || want.made !== res_o.made ||
            want.full !== res_o.full || want.pkts !== res_o.pkts ||
            want.bytes !== res_o.bytes || want.expired !== res_o.expired) begin
          mismatches++;
          if (mismatches <= 10) $display("mismatch: expected %p actual %p", want, res_o);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("tb_flow_table_packet_counter: FAIL");
      $finish;
    end
  end

  initial begin
    for (int i = 0; i < ENTRIES; i++) begin
      tbl_valid[i] = 1'b0;
      tbl_key[i] = '0; tbl_pkts[i] = '0; tbl_bytes[i] = '0; tbl_seen[i] = '0;
      lru_next[i] = 0; lru_prev[i] = 0;
    end
    lru_head = 0; lru_tail = 0; flows_used = 0;
    expiry_cfg = ftpc_pkg::EXPIRY_RESET;
    foreach (key_pool[i]) key_pool[i] = random_key();
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    test_directed();
    test_expiry_settings();
    test_random_traffic(700);
    test_backpressure();
    test_table_fill();
    while (expected_counts.size() != 0) @(posedge clk_i);
    repeat (ENTRIES + 16) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("tb_flow_table_packet_counter: PASS");
    end else begin
      $display("tb_flow_table_packet_counter: FAIL");
    end
    $finish;
  end

endmodule
